// ----- sv/etf_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// etf_pkg: shared types and constants for the escape-time fractal pixel unit
// Field structs, fixed-point constants and the register map.
// -----------------------------------------------------------------------------
package etf_pkg;

  localparam int unsigned CoordWidth = 32;
  localparam int unsigned IterWidth  = 16;
  localparam int unsigned FracBits   = CoordWidth - 8;
  localparam int unsigned MaxSize    = 255;

  typedef logic signed [CoordWidth-1:0] coord_t;

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
  } pix_in_t;

  typedef struct packed {
    logic [IterWidth-1:0] iterations;
    logic                 inside_res;
    logic [7:0]           shade;
  } pix_out_t;

  // work item handed from the mapping front to the iteration back
  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t cre;
    coord_t cim;
  } job_t;

  typedef struct packed {
    logic                 mode;
    logic [IterWidth-1:0] limit;
    logic [7:0]           size;
    logic [30:0]          step;
    coord_t               roff;
    coord_t               ioff;
  } cfg_t;

  typedef enum logic [2:0] {
    RegMode  = 3'd0,
    RegLimit = 3'd1,
    RegSize  = 3'd2,
    RegStep  = 3'd3,
    RegRoff  = 3'd4,
    RegIoff  = 3'd5
  } reg_idx_e;

  localparam coord_t One      = coord_t'(64'd1 << FracBits);
  localparam coord_t JuliaRe  =
    -coord_t'((64'd1 << FracBits) / 10 * 7 + (((64'd1 << FracBits) % 10) * 7 + 5) / 10);
  localparam coord_t JuliaIm  =
    coord_t'(((64'd1 << FracBits) * 27015 + 50000) / 100000);
  localparam logic [CoordWidth:0] Four = (CoordWidth+1)'(64'd4 << FracBits);

  function automatic coord_t sat_add(coord_t a, coord_t b);
    logic signed [CoordWidth:0] s;
    s = {a[CoordWidth-1], a} + {b[CoordWidth-1], b};
    if (s[CoordWidth] != s[CoordWidth-1])
      return s[CoordWidth] ? {1'b1, {(CoordWidth-1){1'b0}}} : {1'b0, {(CoordWidth-1){1'b1}}};
    return s[CoordWidth-1:0];
  endfunction

  // floor(p / 2^FracBits) of a full product, saturated
  function automatic coord_t sat_shift(logic signed [2*CoordWidth-1:0] p);
    logic signed [2*CoordWidth-1:0] q;
    q = p >>> FracBits;
    if (q > (2*CoordWidth)'(signed'({1'b0, {(CoordWidth-1){1'b1}}})))
      return {1'b0, {(CoordWidth-1){1'b1}}};
    if (q < -(2*CoordWidth)'(64'sd1 <<< (CoordWidth-1)))
      return {1'b1, {(CoordWidth-1){1'b0}}};
    return q[CoordWidth-1:0];
  endfunction

endpackage

// ----- sv/escape_time_fractal_pixel_unit.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// escape_time_fractal_pixel_unit: Mandelbrot / Julia escape-time pixel engine
// Maps a pixel to the plane and iterates z = z*z + c in saturating Q8.24.
// -----------------------------------------------------------------------------
// Each iteration of a pixel takes a multiply state (the three squares and
// products) and an update state (the escape test and update); the shade
// division, the result beat and the handoff follow the last iteration. The
// back end iterates one pixel at a time, so its single loop sets the rate.
// A two-stage mapping front end and a five-deep job queue (four RAM entries
// and a head register) let new pixels be pushed while one is iterating. The
// user must write the configuration through APB only while idle; the block
// does not enforce this. Registers sit at byte addresses 0,4,..,20 in the
// order mode, limit, size, step, real offset, imaginary offset.
module escape_time_fractal_pixel_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  etf_pkg::pix_in_t    in_data_i,
  output logic                empty,
  input  logic                pop,
  output etf_pkg::pix_out_t   out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  etf_pkg::cfg_t cfg_q;
  etf_pkg::job_t f_job, q_job;
  logic          in_ready, f_valid, f_ready, q_valid, q_ready;
  logic [2:0]    ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode  <= 1'b0;
      cfg_q.limit <= etf_pkg::IterWidth'(500);
      cfg_q.size  <= 8'd255;
      cfg_q.step  <= 31'd263173;
      cfg_q.roff  <= -etf_pkg::One;
      cfg_q.ioff  <= '0;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        etf_pkg::RegMode:  cfg_q.mode  <= pwdata[0];
        etf_pkg::RegLimit: cfg_q.limit <= pwdata[15:0];
        etf_pkg::RegSize:  cfg_q.size  <= pwdata[7:0];
        etf_pkg::RegStep:  cfg_q.step  <= pwdata[30:0];
        etf_pkg::RegRoff:  cfg_q.roff  <= pwdata;
        etf_pkg::RegIoff:  cfg_q.ioff  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      etf_pkg::RegMode:  prdata = {31'b0, cfg_q.mode};
      etf_pkg::RegLimit: prdata = {16'b0, cfg_q.limit};
      etf_pkg::RegSize:  prdata = {24'b0, cfg_q.size};
      etf_pkg::RegStep:  prdata = {1'b0, cfg_q.step};
      etf_pkg::RegRoff:  prdata = cfg_q.roff;
      etf_pkg::RegIoff:  prdata = cfg_q.ioff;
      default:           prdata = '0;
    endcase
  end

  assign full = !in_ready;

  etf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (push),
    .in_ready_o  (in_ready),
    .in_i        (in_data_i),
    .job_valid_o (f_valid),
    .job_ready_i (f_ready),
    .job_o       (f_job)
  );

  etf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_job),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_job)
  );

  logic res_valid;
  assign empty = !res_valid;

  etf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (cfg_q.limit),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_i       (q_job),
    .res_valid_o (res_valid),
    .res_ready_i (pop),
    .res_o       (out_data_o)
  );
endmodule

// ----- sv/etf_ram.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// etf_ram: generic single-port-write, registered-read RAM
// Used as the job queue storage between front and back.
// -----------------------------------------------------------------------------
module etf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- sv/etf_front.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// etf_front: pixel to plane mapping
// Two-stage pipe: offset products, then halve, saturate and add center.
// -----------------------------------------------------------------------------
module etf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  etf_pkg::cfg_t   cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  etf_pkg::pix_in_t in_i,
  output logic            job_valid_o,
  input  logic            job_ready_i,
  output etf_pkg::job_t   job_o
);
  localparam int unsigned PW = 41; // (2*idx-size) 10b signed times 31b step

  logic              s1_valid_q, s1_valid_d;
  logic signed [PW-1:0] dre_q, dim_q;
  logic              mode_q;
  logic              s1_adv;
  logic signed [9:0] ere, eim;
  logic              out_valid_q;
  etf_pkg::job_t     job_q;
  etf_pkg::coord_t   pr, pi;

  // halve with rounding toward minus infinity, saturate, add center
  function automatic etf_pkg::coord_t map_fn(logic signed [PW-1:0] d,
                                             etf_pkg::coord_t off);
    logic signed [PW-1:0] h;
    etf_pkg::coord_t dc;
    h = d >>> 1;
    if (h > PW'(signed'({1'b0, {(etf_pkg::CoordWidth-1){1'b1}}})))
      dc = {1'b0, {(etf_pkg::CoordWidth-1){1'b1}}};
    else if (h < -PW'(64'sd1 <<< (etf_pkg::CoordWidth-1)))
      dc = {1'b1, {(etf_pkg::CoordWidth-1){1'b0}}};
    else
      dc = h[etf_pkg::CoordWidth-1:0];
    return etf_pkg::sat_add(off, dc);
  endfunction

  assign s1_adv     = !out_valid_q || job_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign s1_valid_d = in_valid_i && in_ready_o ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  assign ere = signed'({1'b0, in_i.col, 1'b0}) - signed'({2'b0, cfg_i.size});
  assign eim = signed'({1'b0, in_i.row, 1'b0}) - signed'({2'b0, cfg_i.size});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (s1_adv) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      dre_q  <= PW'(ere) * PW'(signed'({1'b0, cfg_i.step}));
      dim_q  <= PW'(eim) * PW'(signed'({1'b0, cfg_i.step}));
      mode_q <= cfg_i.mode;
    end
    if (s1_adv && s1_valid_q) begin
      if (mode_q) begin
        job_q.x0  <= pr;
        job_q.y0  <= pi;
        job_q.cre <= etf_pkg::JuliaRe;
        job_q.cim <= etf_pkg::JuliaIm;
      end else begin
        job_q.x0  <= '0;
        job_q.y0  <= '0;
        job_q.cre <= pr;
        job_q.cim <= pi;
      end
    end
  end

  assign pr = map_fn(dre_q, cfg_i.roff);
  assign pi = map_fn(dim_q, cfg_i.ioff);

  assign job_valid_o = out_valid_q;
  assign job_o       = job_q;
endmodule

// ----- sv/etf_queue.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// etf_queue: small job FIFO between front and back
// RAM-backed with a one-entry output register (show-ahead).
// -----------------------------------------------------------------------------
module etf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  etf_pkg::job_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output etf_pkg::job_t rd_data_o
);
  localparam int unsigned Depth = 4;
  localparam int unsigned AW    = $clog2(Depth);

  logic [AW:0]   wp_q, rp_q, cnt;
  logic          wr, rd_mem, fetch_q, head_q;
  etf_pkg::job_t ram_q, head_data_q;

  assign cnt        = wp_q - rp_q;
  assign wr_ready_o = cnt != (AW+1)'(Depth);
  assign wr         = wr_valid_i && wr_ready_o;
  // issue a RAM read when the head slot will be free and nothing is in flight
  assign rd_mem     = (cnt != '0) && !fetch_q && (!head_q || rd_ready_i);

  etf_ram #(.Width($bits(etf_pkg::job_t)), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr),
    .waddr_i (wp_q[AW-1:0]),
    .wdata_i (wr_data_i),
    .raddr_i (rp_q[AW-1:0]),
    .rdata_o (ram_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      fetch_q <= 1'b0;
      head_q  <= 1'b0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd_mem) rp_q <= rp_q + 1'b1;
      fetch_q <= rd_mem;
      if (fetch_q) head_q <= 1'b1;
      else if (rd_ready_i) head_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch_q) head_data_q <= ram_q;
  end

  assign rd_valid_o = head_q;
  assign rd_data_o  = head_data_q;
endmodule

// ----- sv/etf_back.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// etf_back: escape-time iteration engine
// Each iteration runs a multiply state (squares and product), then an update state (escape test and update).
// Shade is formed by a restoring divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module etf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [etf_pkg::IterWidth-1:0] limit_i,
  input  logic             job_valid_i,
  output logic             job_ready_o,
  input  etf_pkg::job_t    job_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output etf_pkg::pix_out_t res_o
);
  localparam int unsigned IW = etf_pkg::IterWidth;
  localparam int unsigned CW = etf_pkg::CoordWidth;
  localparam int unsigned NW = IW + 8;           // cnt*255 width
  localparam int unsigned DC = $clog2(NW + 1);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMul  = 5'b00010,
    StUpd  = 5'b00100,
    StDiv  = 5'b01000,
    StOut  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  etf_pkg::coord_t x_q, y_q, cre_q, cim_q, sx_q, sy_q, xy_q;
  logic [IW-1:0]   cnt_q, lim_q;
  logic [NW-1:0]   num_q;
  logic [NW-1:0]   rem_q;
  logic [NW-1:0]   rem_sh;
  logic [DC-1:0]   dbit_q;
  logic [CW:0]     mag;
  etf_pkg::pix_out_t res_q;
  etf_pkg::coord_t   dxy;

  assign job_ready_o = state_q == StIdle;
  assign res_valid_o = state_q == StOut;
  assign res_o       = res_q;
  assign mag    = {sx_q[CW-1], sx_q} + {sy_q[CW-1], sy_q};
  assign dxy    = etf_pkg::sat_add(xy_q, xy_q);
  assign rem_sh = {rem_q[NW-2:0], num_q[NW-1]};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (job_valid_i) state_d = (limit_i == '0) ? StDiv : StMul;
      StMul:  state_d = StUpd;
      StUpd:  begin
        if (mag > etf_pkg::Four || cnt_q + 1'b1 == lim_q) begin
          state_d = StDiv;
        end else begin
          state_d = StMul;
        end
      end
      StDiv:  if (dbit_q == DC'(NW) || lim_q == '0) state_d = StOut;
      StOut:  if (res_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        x_q    <= job_i.x0;
        y_q    <= job_i.y0;
        cre_q  <= job_i.cre;
        cim_q  <= job_i.cim;
        lim_q  <= limit_i;
        cnt_q  <= '0;
        num_q  <= '0;
        rem_q  <= '0;
        dbit_q <= '0;
      end
      StMul: begin
        sx_q <= etf_pkg::sat_shift((2*CW)'(x_q) * (2*CW)'(x_q));
        sy_q <= etf_pkg::sat_shift((2*CW)'(y_q) * (2*CW)'(y_q));
        xy_q <= etf_pkg::sat_shift((2*CW)'(x_q) * (2*CW)'(y_q));
      end
      StUpd: begin
        // unsigned sum of the two nonnegative squares
        if (!(mag > etf_pkg::Four)) begin
          x_q   <= etf_pkg::sat_add(etf_pkg::sat_add(sx_q, -sy_q), cre_q);
          y_q   <= etf_pkg::sat_add(dxy, cim_q);
          cnt_q <= cnt_q + 1'b1;
          num_q <= NW'(cnt_q + 1'b1) * NW'(255);
        end else begin
          num_q <= NW'(cnt_q) * NW'(255);
        end
      end
      StDiv: begin
        if (dbit_q != DC'(NW)) begin
          if (rem_sh >= NW'(lim_q)) begin
            rem_q <= rem_sh - NW'(lim_q);
            num_q <= {num_q[NW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            num_q <= {num_q[NW-2:0], 1'b0};
          end
          dbit_q <= dbit_q + 1'b1;
        end else begin
          res_q.iterations <= cnt_q;
          res_q.inside_res <= cnt_q == lim_q;
          res_q.shade      <= num_q[7:0];
        end
        if (lim_q == '0) begin
          res_q.iterations <= '0;
          res_q.inside_res <= 1'b1;
          res_q.shade      <= '0;
        end
      end
      default: ;
    endcase
  end
endmodule
